@@ hdl/assert_macros.svh @@
// Assertion macros shared by the list manager RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ALM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle.
`define ALM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the following cycle.
`define ALM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/alm_pkg.sv @@
// Types, constants and the microprogram ROM of the linked list manager.
// No dependencies; used by every other file of the block but the assertion macros and the stream interface.
`default_nettype none

package alm_pkg;

    localparam int DEPTH   = 16;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int COUNT_W = LINK_W;
    localparam int VALUE_W = 32;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam link_t NIL = link_t'(DEPTH);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_AFTER  = 2'd1,
        CMD_BEFORE = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_code_t;

    typedef struct packed {
        logic [1:0]                 command;
        slot_t                      slot_index;
        logic signed [VALUE_W-1:0]  value;
    } cmd_item_t;

    typedef struct packed {
        logic   ok;
        slot_t  slot_used;
        count_t count;
    } res_item_t;

    // Microprogram addresses
    typedef enum logic [3:0] {
        S_APP0, S_APP1,
        S_AFT0, S_AFT1, S_AFT2,
        S_BEF0, S_BEF1,
        S_LNK0, S_LNK1,
        S_REM0, S_REM1, S_REM2, S_REM3,
        S_FAIL
    } ucode_addr_t;

    typedef enum logic {
        FA_FREE,
        FA_IDX
    } fa_sel_t;

    typedef enum logic [2:0] {
        PQ_NONE,
        PQ_APPEND,
        PQ_AFTER,
        PQ_BEFORE,
        PQ_REMOVE
    } pq_sel_t;

    typedef enum logic [2:0] {
        FW_NONE,
        FW_N_Q,
        FW_P_N,
        FW_P_Q,
        FW_IDX_FREE
    } fw_op_t;

    typedef enum logic [2:0] {
        BW_NONE,
        BW_N_P,
        BW_Q_N,
        BW_Q_P,
        BW_IDX_NIL
    } bw_op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_FULL,
        J_BAD,
        J_BAD_OR_FULL
    } jcond_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_NEW,
        RES_IDX
    } res_sel_t;

    typedef struct packed {
        fa_sel_t     fa_sel;
        pq_sel_t     pq_sel;
        logic        alloc;
        logic        release_slot;
        fw_op_t      fw_op;
        bw_op_t      bw_op;
        jcond_t      jcond;
        ucode_addr_t target;
        logic        done;
        res_sel_t    res_sel;
    } uword_t;

    typedef struct packed {
        logic   en;
        uword_t w;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic bad_ref;
        logic out_full;
    } status_t;

    function automatic ucode_addr_t entry_of(logic [1:0] command);
        ucode_addr_t a;
        unique case (cmd_code_t'(command))
            CMD_APPEND: a = S_APP0;
            CMD_AFTER:  a = S_AFT0;
            CMD_BEFORE: a = S_BEF0;
            CMD_REMOVE: a = S_REM0;
        endcase
        return a;
    endfunction

    // Link reads issued in one step return their data in the next step.
    function automatic uword_t ucode_word(ucode_addr_t a);
        uword_t w;
        w.fa_sel       = FA_FREE;
        w.pq_sel       = PQ_NONE;
        w.alloc        = 1'b0;
        w.release_slot = 1'b0;
        w.fw_op        = FW_NONE;
        w.bw_op        = BW_NONE;
        w.jcond        = J_NEXT;
        w.target       = S_FAIL;
        w.done         = 1'b0;
        w.res_sel      = RES_FAIL;
        unique case (a)
            S_APP0:
            begin
                w.jcond = J_FULL;
            end
            S_APP1:
            begin
                w.pq_sel = PQ_APPEND;
                w.alloc  = 1'b1;
                w.jcond  = J_ALWAYS;
                w.target = S_LNK0;
            end
            S_AFT0:
            begin
                w.fa_sel = FA_IDX;
                w.jcond  = J_BAD_OR_FULL;
            end
            S_AFT1:
            begin
                w.pq_sel = PQ_AFTER;
            end
            S_AFT2:
            begin
                w.alloc  = 1'b1;
                w.jcond  = J_ALWAYS;
                w.target = S_LNK0;
            end
            S_BEF0:
            begin
                w.jcond = J_BAD_OR_FULL;
            end
            S_BEF1:
            begin
                w.pq_sel = PQ_BEFORE;
                w.alloc  = 1'b1;
                w.jcond  = J_ALWAYS;
                w.target = S_LNK0;
            end
            S_LNK0:
            begin
                w.fw_op = FW_N_Q;
                w.bw_op = BW_N_P;
            end
            S_LNK1:
            begin
                w.fw_op   = FW_P_N;
                w.bw_op   = BW_Q_N;
                w.done    = 1'b1;
                w.res_sel = RES_NEW;
            end
            S_REM0:
            begin
                w.fa_sel = FA_IDX;
                w.jcond  = J_BAD;
            end
            S_REM1:
            begin
                w.pq_sel = PQ_REMOVE;
            end
            S_REM2:
            begin
                w.fw_op = FW_P_Q;
                w.bw_op = BW_Q_P;
            end
            S_REM3:
            begin
                w.fw_op        = FW_IDX_FREE;
                w.bw_op        = BW_IDX_NIL;
                w.release_slot = 1'b1;
                w.done         = 1'b1;
                w.res_sel      = RES_IDX;
            end
            S_FAIL:
            begin
                w.done = 1'b1;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hdl/alm_stream_if.sv @@
// Valid/ready channel carrying one item of a packed payload type.
// Payload types come from alm_pkg.
`default_nettype none

interface alm_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/array_linked_list_manager.sv @@
// Steps: appends and inserts before take 4 steps, inserts after 5, removes 4 and
// failed commands 2; the result is registered at the end of the final step.
// Commands do not overlap: a new command is accepted only once the previous one has left
// its final step; each link memory has a single read and write port.
// Reset: list empty, free chain 0..DEPTH-1 in order; link entries read as their reset
// values through per-entry written flags, so no clearing pass is needed.
`default_nettype none

module array_linked_list_manager (
    input  logic          clk,
    input  logic          rst_n,
    alm_stream_if.sink    cmd,
    alm_stream_if.source  rsp
);
    import alm_pkg::*;

    ctrl_t     ctl;
    status_t   st;
    logic      busy;
    logic      accept;
    cmd_item_t cmd_item;
    res_item_t rsp_item;

    assign cmd_item  = cmd.data;
    assign cmd.ready = !busy;
    assign accept    = cmd.valid && !busy;

    alm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (cmd_item.command),
        .st      (st),
        .ctl     (ctl),
        .busy    (busy)
    );

    alm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd_data  (cmd_item),
        .ctl       (ctl),
        .st        (st),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp_item)
    );

    assign rsp.data = rsp_item;

endmodule

`default_nettype wire

@@ hdl/alm_seq.sv @@
// Microprogram sequencer: step counter, ROM lookup and conditional jumps.
// Depends on alm_pkg and assert_macros.svh.
`default_nettype none

module alm_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [1:0]      command,
    input  alm_pkg::status_t st,
    output alm_pkg::ctrl_t  ctl,
    output logic            busy
);
    import alm_pkg::*;

    `include "assert_macros.svh"

    ucode_addr_t step_reg, step_next;
    logic        busy_reg, busy_next;
    uword_t      w;
    logic        stall;
    logic        en;
    logic        take;

    assign w     = ucode_word(step_reg);
    // hold the final step while the result register is still occupied
    assign stall = w.done && st.out_full;
    assign en    = busy_reg && !stall;

    always_comb
    begin
        unique case (w.jcond)
            J_NEXT:        take = 1'b0;
            J_ALWAYS:      take = 1'b1;
            J_FULL:        take = st.full;
            J_BAD:         take = st.bad_ref;
            J_BAD_OR_FULL: take = st.bad_ref || st.full;
            default:       take = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            step_next = entry_of(command);
            busy_next = 1'b1;
        end
        else if (en)
        begin
            if (w.done)
                busy_next = 1'b0;
            else if (take)
                step_next = w.target;
            else
                step_next = ucode_addr_t'(step_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_FAIL;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign ctl.en = en;
    assign ctl.w  = w;
    assign busy   = busy_reg;

    `ALM_ASSERT_NEXT(a_stall_holds_step, busy_reg && stall, $stable(step_reg) && busy_reg, "stalled step moved")
    `ALM_ASSERT_NEXT(a_done_ends_item, en && w.done, !busy_reg, "sequencer still busy after final step")

endmodule

`default_nettype wire

@@ hdl/alm_datapath.sv @@
// Datapath: link memories, element store, list pointers and result register.
// Depends on alm_pkg and assert_macros.svh; driven by alm_seq control words.
`default_nettype none

module alm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  alm_pkg::cmd_item_t cmd_data,
    input  alm_pkg::ctrl_t     ctl,
    output alm_pkg::status_t   st,
    input  logic               rsp_ready,
    output logic               rsp_valid,
    output alm_pkg::res_item_t rsp_data
);
    import alm_pkg::*;

    `include "assert_macros.svh"

    // link memories and element store; unwritten link entries read as reset value
    link_t                      fwd_mem   [DEPTH];
    link_t                      bwd_mem   [DEPTH];
    logic signed [VALUE_W-1:0]  store_mem [DEPTH];
    logic [DEPTH-1:0]           fwd_wr_reg;
    logic [DEPTH-1:0]           bwd_wr_reg;

    link_t      fwd_rd_reg, bwd_rd_reg;
    logic       fwd_rd_vld_reg, bwd_rd_vld_reg;
    slot_t      fwd_rd_addr_reg;
    link_t      fwd_rd, bwd_rd;
    slot_t      fwd_raddr;

    slot_t                      idx_reg;
    logic signed [VALUE_W-1:0]  val_reg;
    slot_t                      n_reg;
    link_t                      p_reg, q_reg;
    link_t                      first_reg, first_next;
    link_t                      last_reg, last_next;
    link_t                      free_reg, free_next;
    count_t                     count_reg, count_next;
    logic [DEPTH-1:0]           in_use_reg, in_use_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    res_item_t                  rsp_data_reg;

    logic   fw_we, bw_we;
    slot_t  fw_addr, bw_addr;
    link_t  fw_data, bw_data;
    slot_t  free_slot;

    assign free_slot = free_reg[SLOT_W-1:0];
    assign fwd_raddr = (ctl.w.fa_sel == FA_IDX) ? idx_reg : free_slot;
    assign fwd_rd    = fwd_rd_vld_reg ? fwd_rd_reg
                                      : link_t'({1'b0, fwd_rd_addr_reg}) + link_t'(1);
    assign bwd_rd    = bwd_rd_vld_reg ? bwd_rd_reg : NIL;

    // link writes; a null neighbor moves the head or tail pointer instead
    always_comb
    begin
        fw_we      = 1'b0;
        fw_addr    = n_reg;
        fw_data    = q_reg;
        bw_we      = 1'b0;
        bw_addr    = n_reg;
        bw_data    = p_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (ctl.en)
        begin
            unique case (ctl.w.fw_op)
                FW_NONE: ;
                FW_N_Q:
                begin
                    fw_we = 1'b1;
                end
                FW_P_N:
                begin
                    if (p_reg != NIL)
                    begin
                        fw_we   = 1'b1;
                        fw_addr = p_reg[SLOT_W-1:0];
                        fw_data = {1'b0, n_reg};
                    end
                    else
                        first_next = {1'b0, n_reg};
                end
                FW_P_Q:
                begin
                    if (p_reg != NIL)
                    begin
                        fw_we   = 1'b1;
                        fw_addr = p_reg[SLOT_W-1:0];
                    end
                    else
                        first_next = q_reg;
                end
                FW_IDX_FREE:
                begin
                    fw_we   = 1'b1;
                    fw_addr = idx_reg;
                    fw_data = free_reg;
                end
                default: ;
            endcase
            unique case (ctl.w.bw_op)
                BW_NONE: ;
                BW_N_P:
                begin
                    bw_we = 1'b1;
                end
                BW_Q_N:
                begin
                    if (q_reg != NIL)
                    begin
                        bw_we   = 1'b1;
                        bw_addr = q_reg[SLOT_W-1:0];
                        bw_data = {1'b0, n_reg};
                    end
                    else
                        last_next = {1'b0, n_reg};
                end
                BW_Q_P:
                begin
                    if (q_reg != NIL)
                    begin
                        bw_we   = 1'b1;
                        bw_addr = q_reg[SLOT_W-1:0];
                    end
                    else
                        last_next = p_reg;
                end
                BW_IDX_NIL:
                begin
                    bw_we   = 1'b1;
                    bw_addr = idx_reg;
                    bw_data = NIL;
                end
                default: ;
            endcase
        end
    end

    // free chain, occupancy and element count
    always_comb
    begin
        free_next   = free_reg;
        count_next  = count_reg;
        in_use_next = in_use_reg;
        if (ctl.en && ctl.w.alloc)
        begin
            free_next              = fwd_rd;
            count_next             = count_reg + count_t'(1);
            in_use_next[free_slot] = 1'b1;
        end
        else if (ctl.en && ctl.w.release_slot)
        begin
            free_next            = {1'b0, idx_reg};
            count_next           = count_reg - count_t'(1);
            in_use_next[idx_reg] = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (ctl.en && ctl.w.done)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_wr_reg    <= '0;
            bwd_wr_reg    <= '0;
            in_use_reg    <= '0;
            first_reg     <= NIL;
            last_reg      <= NIL;
            free_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fw_we)
                fwd_wr_reg[fw_addr] <= 1'b1;
            if (bw_we)
                bwd_wr_reg[bw_addr] <= 1'b1;
            in_use_reg    <= in_use_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fw_we)
            fwd_mem[fw_addr] <= fw_data;
        if (bw_we)
            bwd_mem[bw_addr] <= bw_data;
        if (ctl.en && ctl.w.alloc)
            store_mem[free_slot] <= val_reg;
        fwd_rd_reg      <= fwd_mem[fwd_raddr];
        fwd_rd_vld_reg  <= fwd_wr_reg[fwd_raddr];
        fwd_rd_addr_reg <= fwd_raddr;
        bwd_rd_reg      <= bwd_mem[idx_reg];
        bwd_rd_vld_reg  <= bwd_wr_reg[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= cmd_data.slot_index;
            val_reg <= cmd_data.value;
        end
        if (ctl.en && ctl.w.alloc)
            n_reg <= free_slot;
        if (ctl.en)
        begin
            unique case (ctl.w.pq_sel)
                PQ_NONE: ;
                PQ_APPEND:
                begin
                    p_reg <= last_reg;
                    q_reg <= NIL;
                end
                PQ_AFTER:
                begin
                    p_reg <= {1'b0, idx_reg};
                    q_reg <= fwd_rd;
                end
                PQ_BEFORE:
                begin
                    p_reg <= bwd_rd;
                    q_reg <= {1'b0, idx_reg};
                end
                PQ_REMOVE:
                begin
                    p_reg <= bwd_rd;
                    q_reg <= fwd_rd;
                end
                default: ;
            endcase
        end
        if (ctl.en && ctl.w.done)
        begin
            rsp_data_reg.ok    <= (ctl.w.res_sel != RES_FAIL);
            rsp_data_reg.count <= count_next;
            unique case (ctl.w.res_sel)
                RES_NEW:  rsp_data_reg.slot_used <= n_reg;
                RES_IDX:  rsp_data_reg.slot_used <= idx_reg;
                default:  rsp_data_reg.slot_used <= '0;
            endcase
        end
    end

    assign st.full     = (free_reg == NIL);
    assign st.bad_ref  = !in_use_reg[idx_reg];
    assign st.out_full = rsp_valid_reg && !rsp_ready;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp_data    = rsp_data_reg;

    `ALM_ASSERT_IMPLY(a_alloc_has_free, ctl.en && ctl.w.alloc, free_reg != NIL, "slot taken from empty free chain")
    `ALM_ASSERT_IMPLY(a_release_in_use, ctl.en && ctl.w.release_slot, in_use_reg[idx_reg], "freed slot not in use")
    `ALM_ASSERT_ALWAYS(a_count_matches, count_reg == count_t'($countones(in_use_reg)), "count disagrees with occupancy")
    `ALM_ASSERT_IMPLY(a_empty_no_head, count_reg == '0, first_reg == NIL, "empty list keeps a head")

endmodule

`default_nettype wire

@@ tb/list_checker.sv @@
// Checker for the linked list manager: follows the command and result channels,
// keeps its own copy of the list and free chain, and compares every result.
// Depends on alm_pkg for the item types, DEPTH and NIL.
module list_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  logic                       cmd_ready,
    input  alm_pkg::cmd_item_t         cmd_data,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  alm_pkg::res_item_t         rsp_data,
    output int                         errors,
    output int                         pending,
    output int                         compared,
    output logic [alm_pkg::DEPTH-1:0]  live_slots,
    output alm_pkg::count_t            live_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import alm_pkg::*;

    link_t            next_of[DEPTH];
    link_t            prev_of[DEPTH];
    logic [DEPTH-1:0] occupied;
    link_t            head_slot;
    link_t            tail_slot;
    link_t            free_top;
    count_t           n_elems;
    res_item_t        expected_results[$];

    assign live_slots = occupied;
    assign live_count = n_elems;

    // Put slot s between p and q; a NIL neighbor moves the head or tail instead.
    function automatic void splice_in(slot_t s, link_t p, link_t q);
        prev_of[s] = p;
        next_of[s] = q;
        if (p != NIL)
            next_of[p[SLOT_W-1:0]] = link_t'(s);
        else
            head_slot = link_t'(s);
        if (q != NIL)
            prev_of[q[SLOT_W-1:0]] = link_t'(s);
        else
            tail_slot = link_t'(s);
    endfunction

    // Pop the free chain head and mark it live.
    function automatic slot_t grab_free();
        slot_t s;
        s = free_top[SLOT_W-1:0];
        free_top = next_of[s];
        occupied[s] = 1'b1;
        n_elems = n_elems + 1'b1;
        return s;
    endfunction

    function automatic res_item_t apply_command(cmd_item_t c);
        res_item_t r;
        slot_t     s;
        slot_t     anchor;
        link_t     p;
        link_t     q;
        r.ok = 1'b0;
        r.slot_used = '0;
        anchor = c.slot_index;
        case (cmd_code_t'(c.command))
            CMD_APPEND:
            begin
                if (free_top != NIL)
                begin
                    s = grab_free();
                    splice_in(s, tail_slot, NIL);
                    r.ok = 1'b1;
                    r.slot_used = s;
                end
            end
            CMD_AFTER, CMD_BEFORE:
            begin
                if (occupied[anchor] && free_top != NIL)
                begin
                    s = grab_free();
                    if (cmd_code_t'(c.command) == CMD_AFTER)
                        splice_in(s, link_t'(anchor), next_of[anchor]);
                    else
                        splice_in(s, prev_of[anchor], link_t'(anchor));
                    r.ok = 1'b1;
                    r.slot_used = s;
                end
            end
            default:
            begin
                if (occupied[anchor])
                begin
                    p = prev_of[anchor];
                    q = next_of[anchor];
                    if (p != NIL)
                        next_of[p[SLOT_W-1:0]] = q;
                    else
                        head_slot = q;
                    if (q != NIL)
                        prev_of[q[SLOT_W-1:0]] = p;
                    else
                        tail_slot = p;
                    occupied[anchor] = 1'b0;
                    prev_of[anchor] = NIL;
                    next_of[anchor] = free_top;
                    free_top = link_t'(anchor);
                    n_elems = n_elems - 1'b1;
                    r.ok = 1'b1;
                    r.slot_used = anchor;
                end
            end
        endcase
        r.count = n_elems;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                next_of[i] = link_t'(i + 1);
                prev_of[i] = NIL;
            end
            occupied  = '0;
            head_slot = NIL;
            tail_slot = NIL;
            free_top  = '0;
            n_elems   = '0;
            expected_results.delete();
            errors    = 0;
            compared  = 0;
            pending   = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                expected_results.push_back(apply_command(cmd_data));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no command outstanding: ok %0d slot %0d count %0d",
                           rsp_data.ok, rsp_data.slot_used, rsp_data.count);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compared++;
                    if (rsp_data.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, rsp_data.ok);
                        errors++;
                    end
                    if (rsp_data.slot_used !== want.slot_used)
                    begin
                        $error("slot_used: expected %0d, got %0d",
                               want.slot_used, rsp_data.slot_used);
                        errors++;
                    end
                    if (rsp_data.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, rsp_data.count);
                        errors++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Top of the linked list manager testbench: clock, reset, command stimulus and
// result-side stalls, with list_checker doing all prediction and comparison.
// Depends on alm_pkg, alm_stream_if, list_checker and array_linked_list_manager.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alm_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 12;

    logic             clk;
    logic             rst_n;
    logic             calm;
    int               cycles;
    int               errors;
    int               pending;
    int               compared;
    int               sent;
    int               full_hits;
    int               empty_hits;
    logic [DEPTH-1:0] live_slots;
    count_t           live_count;

    alm_stream_if #(.payload_t(cmd_item_t)) cmd_ch ();
    alm_stream_if #(.payload_t(res_item_t)) rsp_ch ();

    array_linked_list_manager u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    list_checker u_list_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_ch.valid),
        .cmd_ready  (cmd_ch.ready),
        .cmd_data   (cmd_ch.data),
        .rsp_valid  (rsp_ch.valid),
        .rsp_ready  (rsp_ch.ready),
        .rsp_data   (rsp_ch.data),
        .errors     (errors),
        .pending    (pending),
        .compared   (compared),
        .live_slots (live_slots),
        .live_count (live_count)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic slot_t pick_live();
        int picks[$];
        for (int i = 0; i < DEPTH; i++)
            if (live_slots[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return slot_t'($urandom_range(0, DEPTH - 1));
        return slot_t'(picks[$urandom_range(0, picks.size() - 1)]);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high across back-to-back items.
    task automatic send(cmd_code_t op, slot_t at, logic [31:0] val);
        cmd_item_t it;
        int        gap;
        it.command    = op;
        it.slot_index = at;
        it.value      = val;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        if (live_count == DEPTH)
            full_hits++;
        if (live_count == 0)
            empty_hits++;
    endtask

    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic run_random(int n);
        logic      grow;
        int        r;
        cmd_code_t op;
        slot_t     at;
        grow = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == n / 2)
            begin
                cmd_ch.valid <= 1'b0;
                wait_idle();
            end
            if (live_count == DEPTH)
                grow = 1'b0;
            else if (live_count == 0)
                grow = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                grow = !grow;
            r = $urandom_range(0, 99);
            if (grow)
                op = (r < 35) ? CMD_APPEND : (r < 60) ? CMD_AFTER :
                     (r < 85) ? CMD_BEFORE : CMD_REMOVE;
            else
                op = (r < 70) ? CMD_REMOVE : (r < 80) ? CMD_APPEND :
                     (r < 90) ? CMD_AFTER : CMD_BEFORE;
            at = ($urandom_range(0, 99) < 85) ? pick_live() : slot_t'($urandom);
            send(op, at, pick_value());
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls, none while calm.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                rsp_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        calm         = 1'b0;
        sent         = 0;
        full_hits    = 0;
        empty_hits   = 0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Commands on an empty list must fail.
        send(CMD_REMOVE, 4'd0, 32'h0);
        send(CMD_AFTER, 4'd3, 32'h1234_5678);
        send(CMD_BEFORE, 4'd9, 32'hFFFF_FFFF);
        // Build 3,0,4,5,1,2 from both ends and the middle.
        send(CMD_APPEND, 4'd15, 32'h7FFF_FFFF);
        send(CMD_APPEND, 4'd0, 32'h8000_0000);
        send(CMD_AFTER, 4'd1, 32'h0);
        send(CMD_BEFORE, 4'd0, 32'hFFFF_FFFF);
        send(CMD_AFTER, 4'd0, 32'hA5A5_A5A5);
        send(CMD_BEFORE, 4'd1, 32'h5A5A_5A5A);
        // Remove head, tail, middle, then a slot already freed.
        send(CMD_REMOVE, 4'd3, 32'h0);
        send(CMD_REMOVE, 4'd2, 32'h0);
        send(CMD_REMOVE, 4'd4, 32'h0);
        send(CMD_REMOVE, 4'd4, 32'hFFFF_FFFF);
        send(CMD_AFTER, 4'd15, 32'h1);
        // Fill the store, then every insert must fail.
        while (live_count < DEPTH)
            send(CMD_APPEND, 4'd0, $urandom);
        send(CMD_APPEND, 4'd0, 32'h1);
        send(CMD_AFTER, 4'd0, 32'h2);
        send(CMD_BEFORE, 4'd5, 32'h3);

        run_random(RANDOM_ITEMS);

        cmd_ch.valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Drove %0d commands and compared %0d results.", sent, compared);
        $display("The list was full after %0d commands and empty after %0d.",
                 full_hits, empty_hits);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
